// ----- rtl/tss_pkg.sv -----
// Package for the thread scheduler: event kinds, thread states, status codes,
// sequencer states and the beat types of both channels. No dependencies.
`timescale 1ns / 1ps
package tss_pkg;

  typedef enum logic [3:0] {
    K_YIELD     = 4'd0,
    K_FORK      = 4'd1,
    K_EXIT      = 4'd2,
    K_LOCK      = 4'd3,
    K_UNLOCK    = 4'd4,
    K_WAIT      = 4'd5,
    K_SIGNAL    = 4'd6,
    K_BROADCAST = 4'd7,
    K_JOIN      = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    ST_FREE    = 3'd0,
    ST_RUNNING = 3'd1,
    ST_READY   = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_DONE    = 3'd4
  } tstat_t;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT = 2'd1;
  localparam logic [1:0] STAT_NOT_OWN = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_RD,
    S_POP_DONE,
    S_WAKE,
    S_PARK,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    R_YIELD,
    R_UNLOCK,
    R_WAKE
  } pop_role_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] mutex_index;
    logic [2:0] cond_index;
    logic [3:0] join_thread;
  } event_beat_t;

  typedef struct packed {
    logic [3:0] running_thread;
    logic       switched;
    logic [3:0] forked_slot;
    logic       join_done;
    logic [1:0] status;
  } result_beat_t;

endpackage

// ----- rtl/tss_if.sv -----
// Valid/ready channel for one beat of payload of type T.
// Depends on nothing.
`timescale 1ns / 1ps
interface tss_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/thread_scheduler_sync_engine.sv -----
// Top level of the thread scheduler: sequencer over the link memory.
// Depends on tss_pkg, tss_if and tss_ram.
//
//  channel  dir  beat contents
//  evt      in   kind, mutex_index, cond_index, join_thread
//  res      out  running_thread, switched, forked_slot, join_done, status
//
// A result is registered in S_OUT after its event is dispatched. Each dequeue
// goes through the registered link read (S_POP_RD, S_POP_DONE), each wakeup
// push through S_WAKE and the condition park of a wait through S_PARK; a
// broadcast wakes its threads one after another. Reset is synchronous and
// leaves slot 0 running. A result waits in its output register until taken,
// and the next event is accepted in the cycle after that.
`timescale 1ns / 1ps
module thread_scheduler_sync_engine #(
  parameter int THREAD_SLOTS = 16,
  parameter int MUTEX_COUNT  = 8,
  parameter int COND_COUNT   = 8
) (
  input logic clk,
  input logic rst,
  tss_if.sink   evt,
  tss_if.source res
);
  import tss_pkg::*;

  localparam int TW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int QC = 1 + MUTEX_COUNT + COND_COUNT;
  localparam int QW = $clog2(QC);
  localparam int MW = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
  localparam int CTW = $clog2(THREAD_SLOTS + 1);
  localparam logic [QW-1:0] READY_Q = '0;

  state_t state, state_next;

  tstat_t        tstat [THREAD_SLOTS];
  logic [TW-1:0] run_id;
  logic [TW-1:0] start_id;
  logic [TW-1:0] qhead [QC];
  logic [TW-1:0] qtail [QC];
  logic          qne   [QC];
  logic          mheld [MUTEX_COUNT];
  logic [TW-1:0] mown  [MUTEX_COUNT];

  logic [3:0]     kind;
  logic [MW-1:0]  m_idx;
  logic [QW-1:0]  cq;
  logic [3:0]     jt;
  logic [1:0]     stat;
  logic [TW-1:0]  newt;
  logic           jdone;
  logic [CTW-1:0] cnt;
  logic [QW-1:0]  pop_q, pop_q_next;
  pop_role_t      pop_role, role_next;
  logic           ld_pop;
  logic [TW-1:0]  woken;

  logic          push_en;
  logic [QW-1:0] push_q;
  logic [TW-1:0] push_t;

  logic          lk_we;
  logic [TW-1:0] lk_wa, lk_wd, lk_ra, lk_rd;

  tss_ram #(.WIDTH(TW), .DEPTH(THREAD_SLOTS)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd)
  );

  logic [3:0] r_run, r_new;
  logic       r_sw, r_jd;
  logic [1:0] r_st;

  function automatic logic [MW-1:0] wrap_m(input logic [2:0] v);
    logic [MW-1:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) if (v == 3'(k)) r = MW'(k % MUTEX_COUNT);
    return r;
  endfunction

  function automatic logic [QW-1:0] cond_q(input logic [2:0] v);
    logic [QW-1:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) if (v == 3'(k)) r = QW'(1 + MUTEX_COUNT + k % COND_COUNT);
    return r;
  endfunction

  function automatic logic [QW-1:0] mq(input logic [MW-1:0] m);
    return QW'(32'(m) + 1);
  endfunction

  assign evt.ready = (state == S_IDLE) && !res.valid;
  assign res.data.running_thread = r_run;
  assign res.data.switched       = r_sw;
  assign res.data.forked_slot    = r_new;
  assign res.data.join_done      = r_jd;
  assign res.data.status         = r_st;

  logic          ready_ne;
  logic          running_now;
  logic          owner_ok;
  logic          join_hit;
  logic          free_found;
  logic [TW-1:0] free_idx;
  logic [TW-1:0] pop_h;
  logic          pop_last;

  assign ready_ne    = qne[READY_Q];
  assign running_now = (tstat[run_id] == ST_RUNNING);
  assign owner_ok    = mheld[m_idx] && (mown[m_idx] == run_id);
  assign join_hit    = (32'(jt) < THREAD_SLOTS) && (tstat[TW'(jt)] == ST_DONE);
  assign pop_h       = qhead[pop_q];
  assign pop_last    = (pop_h == qtail[pop_q]);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (tstat[i] == ST_FREE) begin
        free_found = 1'b1;
        free_idx   = TW'(i);
      end
    end
  end

  // The tail link is never read, so a push writes only the old tail's link.
  always_comb begin
    lk_we = push_en && qne[push_q];
    lk_wa = qtail[push_q];
    lk_wd = push_t;
    lk_ra = pop_h;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    push_en    = 1'b0;
    push_q     = READY_Q;
    push_t     = run_id;
    ld_pop     = 1'b0;
    pop_q_next = READY_Q;
    role_next  = R_YIELD;
    case (state)
      S_IDLE: begin
        if (evt.valid && evt.ready) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_next = S_OUT;
        case (kind)
          K_YIELD: begin
            if (ready_ne) begin
              push_en = running_now; ld_pop = 1'b1; state_next = S_POP_RD;
            end
          end
          K_FORK: begin
            if (free_found) push_en = running_now;
          end
          K_EXIT: begin
            if (ready_ne) begin
              ld_pop = 1'b1; state_next = S_POP_RD;
            end
          end
          K_LOCK: begin
            if (mheld[m_idx]) begin
              push_en = running_now;
              push_q  = mq(m_idx);
              if (ready_ne) begin
                ld_pop = 1'b1; state_next = S_POP_RD;
              end
            end
          end
          K_UNLOCK, K_WAIT: begin
            if (owner_ok && qne[mq(m_idx)]) begin
              ld_pop = 1'b1; pop_q_next = mq(m_idx); role_next = R_UNLOCK;
              state_next = S_POP_RD;
            end else if (kind == K_WAIT) begin
              state_next = S_PARK;
            end
          end
          K_SIGNAL, K_BROADCAST: begin
            if (qne[cq]) begin
              ld_pop = 1'b1; pop_q_next = cq; role_next = R_WAKE; state_next = S_POP_RD;
            end
          end
          K_JOIN: begin
            if (!join_hit && ready_ne) begin
              push_en = running_now; ld_pop = 1'b1; state_next = S_POP_RD;
            end
          end
          default: ;
        endcase
      end
      S_POP_RD: state_next = S_POP_DONE;
      S_POP_DONE: state_next = (pop_role == R_YIELD) ? S_OUT : S_WAKE;
      S_WAKE: begin
        push_en    = 1'b1;
        push_t     = woken;
        state_next = S_OUT;
        if (pop_role == R_UNLOCK) begin
          if (kind == K_WAIT) state_next = S_PARK;
        end else if (kind == K_BROADCAST && 32'(cnt) < THREAD_SLOTS && qne[cq]) begin
          ld_pop = 1'b1; pop_q_next = cq; role_next = R_WAKE; state_next = S_POP_RD;
        end
      end
      S_PARK: begin
        push_en    = running_now;
        push_q     = cq;
        state_next = S_OUT;
        if (ready_ne) begin
          ld_pop = 1'b1; state_next = S_POP_RD;
        end
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREAD_SLOTS; i++) tstat[i] <= (i == 0) ? ST_RUNNING : ST_FREE;
      for (int i = 0; i < QC; i++) qne[i] <= 1'b0;
      for (int i = 0; i < MUTEX_COUNT; i++) mheld[i] <= 1'b0;
      run_id    <= '0;
      res.valid <= 1'b0;
    end else begin
      if (state == S_OUT) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
      if (push_en) begin
        if (!qne[push_q]) qhead[push_q] <= push_t;
        qtail[push_q] <= push_t;
        qne[push_q]   <= 1'b1;
      end
      if (ld_pop) begin
        pop_q    <= pop_q_next;
        pop_role <= role_next;
      end
      case (state)
        S_IDLE: begin
          if (evt.valid && evt.ready) begin
            kind     <= evt.data.kind;
            m_idx    <= wrap_m(evt.data.mutex_index);
            cq       <= cond_q(evt.data.cond_index);
            jt       <= evt.data.join_thread;
            stat     <= STAT_OK;
            newt     <= '0;
            jdone    <= 1'b0;
            start_id <= run_id;
          end
        end
        S_DISPATCH: begin
          case (kind)
            K_YIELD: begin
              if (ready_ne && running_now) tstat[run_id] <= ST_READY;
            end
            K_FORK: begin
              if (free_found) begin
                if (running_now) tstat[run_id] <= ST_READY;
                tstat[free_idx] <= ST_RUNNING;
                run_id <= free_idx;
                newt   <= free_idx;
              end else begin
                stat <= STAT_NO_SLOT;
              end
            end
            K_EXIT: begin
              if (running_now) tstat[run_id] <= ST_DONE;
            end
            K_LOCK: begin
              if (mheld[m_idx]) begin
                if (running_now) tstat[run_id] <= ST_BLOCKED;
              end else begin
                mheld[m_idx] <= 1'b1;
                mown[m_idx]  <= run_id;
              end
            end
            K_UNLOCK, K_WAIT: begin
              if (!owner_ok) stat <= STAT_NOT_OWN;
              else mheld[m_idx] <= 1'b0;
            end
            K_SIGNAL, K_BROADCAST: begin
              cnt <= '0;
            end
            K_JOIN: begin
              if (join_hit) jdone <= 1'b1;
              else if (ready_ne && running_now) tstat[run_id] <= ST_READY;
            end
            default: ;
          endcase
        end
        S_POP_DONE: begin
          if (pop_last) qne[pop_q] <= 1'b0;
          else qhead[pop_q] <= lk_rd;
          case (pop_role)
            R_YIELD: begin
              tstat[pop_h] <= ST_RUNNING;
              run_id       <= pop_h;
            end
            R_UNLOCK: begin
              mheld[m_idx] <= 1'b1;
              mown[m_idx]  <= pop_h;
              woken        <= pop_h;
            end
            R_WAKE: begin
              woken <= pop_h;
              cnt   <= cnt + CTW'(1);
            end
            default: ;
          endcase
        end
        S_WAKE: begin
          tstat[woken] <= ST_READY;
        end
        S_PARK: begin
          if (running_now) tstat[run_id] <= ST_BLOCKED;
        end
        S_OUT: begin
          r_run <= 4'(run_id);
          r_sw  <= (run_id != start_id);
          r_new <= 4'(newt);
          r_jd  <= jdone;
          r_st  <= stat;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- test/testbench.sv -----
// Testbench for thread_scheduler_sync_engine: directed and random event beats,
// checked against a behavioral scheduler model. Depends on tss_pkg, tss_if and the RTL.
`timescale 1ns / 1ps
module testbench;
  import tss_pkg::*;

  localparam int SLOTS = 16;
  localparam int MUTEXES = 8;
  localparam int CONDS = 8;
  localparam int QUEUES = 1 + MUTEXES + CONDS;
  localparam int READY_QUEUE = 0;
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst;
  tss_if #(.T(event_beat_t)) evt ();
  tss_if #(.T(result_beat_t)) res ();

  thread_scheduler_sync_engine DUT (.clk(clk), .rst(rst), .evt(evt), .res(res));

  tstat_t slot_state[SLOTS];
  int unsigned current_slot;
  int unsigned link[SLOTS];
  int unsigned qhead[QUEUES];
  int unsigned qtail[QUEUES];
  bit qbusy[QUEUES];
  bit mtx_held[MUTEXES];
  int unsigned mtx_owner[MUTEXES];

  result_beat_t pending_results[$];
  int errors = 0;
  bit idle_enable = 1;
  bit hold_request = 0;
  int stall_count = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void enqueue(int q, int unsigned t);
    link[t] = t;
    if (qbusy[q]) begin
      link[qtail[q]] = t;
    end else begin
      qhead[q] = t;
    end
    qtail[q] = t;
    qbusy[q] = 1;
  endfunction

  function automatic int dequeue(int q);
    int unsigned h;
    if (!qbusy[q]) return -1;
    h = qhead[q];
    if (h == qtail[q]) begin
      qbusy[q] = 0;
    end else begin
      qhead[q] = link[h];
    end
    return h;
  endfunction

  function automatic void park_current(int q, tstat_t st);
    if (slot_state[current_slot] == ST_RUNNING) begin
      slot_state[current_slot] = st;
      enqueue(q, current_slot);
    end
  endfunction

  function automatic void yield_current();
    int nxt;
    if (!qbusy[READY_QUEUE]) return;
    park_current(READY_QUEUE, ST_READY);
    nxt = dequeue(READY_QUEUE);
    if (nxt >= 0) begin
      slot_state[nxt] = ST_RUNNING;
      current_slot = nxt;
    end
  endfunction

  function automatic void make_ready(int unsigned t);
    slot_state[t] = ST_READY;
    enqueue(READY_QUEUE, t);
  endfunction

  function automatic logic [1:0] release_mutex(int m);
    int w;
    if (!mtx_held[m] || mtx_owner[m] != current_slot) return STAT_NOT_OWN;
    mtx_held[m] = 0;
    w = dequeue(1 + m);
    if (w >= 0) begin
      make_ready(w);
      mtx_held[m] = 1;
      mtx_owner[m] = w;
    end
    return STAT_OK;
  endfunction

  function automatic result_beat_t schedule_event(event_beat_t e);
    result_beat_t r;
    int m;
    int cq;
    int unsigned start;
    int t;
    int i;
    m = e.mutex_index % MUTEXES;
    cq = 1 + MUTEXES + (e.cond_index % CONDS);
    start = current_slot;
    r = '0;
    r.status = STAT_OK;
    case (e.kind)
      K_YIELD: yield_current();
      K_FORK: begin
        for (i = 0; i < SLOTS; i++) if (slot_state[i] == ST_FREE) break;
        if (i >= SLOTS) begin
          r.status = STAT_NO_SLOT;
        end else begin
          park_current(READY_QUEUE, ST_READY);
          slot_state[i] = ST_RUNNING;
          current_slot = i;
          r.forked_slot = 4'(i);
        end
      end
      K_EXIT: begin
        if (slot_state[current_slot] == ST_RUNNING) slot_state[current_slot] = ST_DONE;
        yield_current();
      end
      K_LOCK: begin
        if (mtx_held[m]) begin
          park_current(1 + m, ST_BLOCKED);
          yield_current();
        end else begin
          mtx_held[m] = 1;
          mtx_owner[m] = current_slot;
        end
      end
      K_UNLOCK: r.status = release_mutex(m);
      K_WAIT: begin
        r.status = release_mutex(m);
        park_current(cq, ST_BLOCKED);
        yield_current();
      end
      K_SIGNAL: begin
        t = dequeue(cq);
        if (t >= 0) make_ready(t);
      end
      K_BROADCAST: begin
        for (i = 0; i < SLOTS; i++) begin
          t = dequeue(cq);
          if (t < 0) break;
          make_ready(t);
        end
      end
      K_JOIN: begin
        if (int'(e.join_thread) < SLOTS && slot_state[e.join_thread] == ST_DONE) begin
          r.join_done = 1;
        end else begin
          yield_current();
        end
      end
      default: ;
    endcase
    r.running_thread = 4'(current_slot);
    r.switched = (current_slot != start);
    return r;
  endfunction

  task automatic send_event(logic [3:0] kind, logic [2:0] m, logic [2:0] c, logic [3:0] j);
    event_beat_t e;
    int gap;
    e.kind = kind;
    e.mutex_index = m;
    e.cond_index = c;
    e.join_thread = j;
    gap = idle_enable ? $urandom_range(0, 9) : 0;
    repeat (gap) begin
      @(negedge clk);
      evt.valid <= 1'b0;
    end
    @(negedge clk);
    evt.valid <= 1'b1;
    evt.data <= e;
    do @(posedge clk); while (!evt.ready);
    pending_results.push_back(schedule_event(e));
  endtask

  always @(posedge clk) begin
    result_beat_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, res.data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res.data.running_thread !== want.running_thread) begin
          $display("%0t: running_thread expected %0d actual %0d", $time,
                   want.running_thread, res.data.running_thread);
          errors++;
        end
        if (res.data.switched !== want.switched) begin
          $display("%0t: switched expected %0d actual %0d", $time,
                   want.switched, res.data.switched);
          errors++;
        end
        if (res.data.forked_slot !== want.forked_slot) begin
          $display("%0t: forked_slot expected %0d actual %0d", $time,
                   want.forked_slot, res.data.forked_slot);
          errors++;
        end
        if (res.data.join_done !== want.join_done) begin
          $display("%0t: join_done expected %0d actual %0d", $time,
                   want.join_done, res.data.join_done);
          errors++;
        end
        if (res.data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, res.data.status);
          errors++;
        end
      end
    end
  end

  initial begin
    int gap;
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = idle_enable ? $urandom_range(0, 9) : 0;
      if (hold_request) begin
        gap = 300;
        hold_request = 0;
      end
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (evt.valid && evt.ready) || (res.valid && res.ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("thread_scheduler_sync_engine test failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic test_fork_and_exit();
    send_event(K_YIELD, 0, 0, 0);
    for (int i = 0; i < 15; i++) send_event(K_FORK, 0, 0, 0);
    send_event(K_FORK, 3'd7, 3'd7, 4'd15);
    send_event(K_EXIT, 0, 0, 0);
    send_event(K_JOIN, 0, 0, 4'd15);
    send_event(K_JOIN, 0, 0, 4'd0);
    send_event(K_YIELD, 0, 0, 0);
  endtask

  task automatic test_mutex();
    send_event(K_UNLOCK, 3'd7, 0, 0);
    send_event(K_LOCK, 3'd7, 0, 0);
    send_event(K_LOCK, 3'd7, 0, 0);
    send_event(K_LOCK, 3'd7, 0, 0);
    send_event(K_UNLOCK, 3'd7, 0, 0);
    send_event(K_UNLOCK, 3'd0, 0, 0);
  endtask

  task automatic test_condition();
    send_event(K_LOCK, 3'd2, 0, 0);
    send_event(K_WAIT, 3'd2, 3'd7, 0);
    send_event(K_WAIT, 3'd5, 3'd7, 0);
    send_event(K_SIGNAL, 0, 3'd7, 0);
    send_event(K_BROADCAST, 0, 3'd7, 0);
    for (int k = 9; k < 16; k++) send_event(k[3:0], 3'd7, 3'd7, 4'd15);
  endtask

  task automatic test_random_events(int count);
    int pick;
    logic [3:0] kind;
    for (int n = 0; n < count; n++) begin
      idle_enable = ((n / 100) % 3) != 2;
      pick = $urandom_range(0, 99);
      if (pick < 15) kind = K_YIELD;
      else if (pick < 20) kind = K_FORK;
      else if (pick < 24) kind = K_EXIT;
      else if (pick < 42) kind = K_LOCK;
      else if (pick < 60) kind = K_UNLOCK;
      else if (pick < 72) kind = K_WAIT;
      else if (pick < 82) kind = K_SIGNAL;
      else if (pick < 88) kind = K_BROADCAST;
      else if (pick < 96) kind = K_JOIN;
      else kind = 4'($urandom_range(9, 15));
      send_event(kind, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                 4'($urandom_range(0, 15)));
    end
    idle_enable = 1;
  endtask

  task automatic test_output_backpressure();
    hold_request = 1;
    for (int n = 0; n < 6; n++) send_event(K_YIELD, 0, 0, 0);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_state[i] = ST_FREE;
      link[i] = 0;
    end
    for (int q = 0; q < QUEUES; q++) begin
      qhead[q] = 0;
      qtail[q] = 0;
      qbusy[q] = 0;
    end
    for (int m = 0; m < MUTEXES; m++) begin
      mtx_held[m] = 0;
      mtx_owner[m] = 0;
    end
    slot_state[0] = ST_RUNNING;
    current_slot = 0;
    rst = 1'b1;
    evt.valid = 1'b0;
    evt.data = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_mutex();
    test_condition();
    test_fork_and_exit();
    test_output_backpressure();
    test_random_events(820);
    @(negedge clk);
    evt.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("thread_scheduler_sync_engine test passed");
    end else begin
      $display("thread_scheduler_sync_engine test failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/tss_pkg.sv
rtl/tss_if.sv
rtl/tss_ram.sv
rtl/thread_scheduler_sync_engine.sv
test/testbench.sv
